>>> rtl/sht_pkg.sv
// Shared types and constants for the two-wire sensor bus measurement master.
package sht_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd50;
  localparam logic [3:0]  CMD_BITS          = 4'd8;
  localparam logic        CFG_IDX_HALF      = 1'b0;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_S1         = 5'd1,
    PH_S2         = 5'd2,
    PH_S3         = 5'd3,
    PH_S4         = 5'd4,
    PH_S5         = 5'd5,
    PH_S6         = 5'd6,
    PH_CMD_SETUP  = 5'd7,
    PH_CMD_HIGH   = 5'd8,
    PH_ACK_SETUP  = 5'd9,
    PH_ACK_HIGH   = 5'd10,
    PH_WAIT_REL   = 5'd11,
    PH_WAIT_LOW   = 5'd12,
    PH_RD_SETUP   = 5'd13,
    PH_RD_HIGH    = 5'd14,
    PH_RACK_SETUP = 5'd15,
    PH_RACK_HIGH  = 5'd16,
    PH_RACK_TAIL  = 5'd17
  } phase_t;

  typedef struct packed {
    logic        clock_out;
    logic        data_pull_low;
    logic        busy_res;
    logic        done_res;
    logic        no_ack;
    logic [15:0] measurement;
  } sht_result_t;

endpackage

>>> rtl/sht_if.sv
// Valid/ready channel interfaces for the tick input and the per-tick result.
interface sht_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] command;
  logic       data_line;

  modport source (output valid, output start_req, output command, output data_line,
                  input ready);
  modport sink (input valid, input start_req, input command, input data_line,
                output ready);
endinterface

interface sht_out_if;
  logic        valid;
  logic        ready;
  logic        clock_out;
  logic        data_pull_low;
  logic        busy_res;
  logic        done_res;
  logic        no_ack;
  logic [15:0] measurement;

  modport source (output valid, output clock_out, output data_pull_low, output busy_res,
                  output done_res, output no_ack, output measurement, input ready);
  modport sink (input valid, input clock_out, input data_pull_low, input busy_res,
                input done_res, input no_ack, input measurement, output ready);
endinterface

>>> rtl/sht_two_wire_measure_master_core.sv
// Top level of the two-wire sensor bus measurement master.
// Every input beat yields exactly one result beat, registered in the cycle after it is accepted.
// A new input beat is taken in every cycle while the result register is empty or drained.
// The sequencer state advances once per accepted beat, in a single registered pass.
// Synchronous active-low reset idles the sequencer, clears its state and sets the
// half period to 50 ticks.
module sht_two_wire_measure_master_core import sht_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sht_in_if.sink                in_ch,
  sht_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic        [15:0] half_period;
  logic               accept;
  sht_result_t        result;
  sht_result_t        res_r;
  logic               out_valid_r;
  logic               out_valid_nxt;

  sht_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .half_period (half_period)
  );

  sht_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (accept),
    .half_period (half_period),
    .start_req   (in_ch.start_req),
    .command     (in_ch.command),
    .data_line   (in_ch.data_line),
    .result      (result)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= result;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.clock_out     = res_r.clock_out;
  assign out_ch.data_pull_low = res_r.data_pull_low;
  assign out_ch.busy_res      = res_r.busy_res;
  assign out_ch.done_res      = res_r.done_res;
  assign out_ch.no_ack        = res_r.no_ack;
  assign out_ch.measurement   = res_r.measurement;

endmodule

>>> rtl/sht_cfg.sv
// APB-style configuration register holding the half period in ticks.
module sht_cfg import sht_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output logic [15:0]           half_period
);

  logic [15:0] half_r;
  logic [15:0] half_nxt;
  logic        hit;

  assign hit        = (cfg_paddr[CFG_ADDR_W-1] == CFG_IDX_HALF);
  assign cfg_pready = 1'b1;

  always_comb begin
    half_nxt = half_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && hit) begin
      half_nxt = cfg_pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_PERIOD_RESET;
    end else begin
      half_r <= half_nxt;
    end
  end

  assign cfg_prdata  = hit ? {{(CFG_DATA_W-16){1'b0}}, half_r} : '0;
  assign half_period = half_r;

endmodule

>>> rtl/sht_seq.sv
// Bus sequencer: phase state machine, bit and tick counters, line levels.
module sht_seq import sht_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [15:0] half_period,
  input  logic        start_req,
  input  logic [7:0]  command,
  input  logic        data_line,
  output sht_result_t result
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [15:0] shift_r, shift_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] value_r, value_nxt;
  logic        clk_r, clk_nxt;
  logic        drv_r, drv_nxt;
  logic        enter;
  logic        done;
  logic        err;
  logic [15:0] hp;
  logic [15:0] tick_inc;
  logic [3:0]  bit_inc;

  assign hp       = (half_period == 16'd0) ? 16'd1 : half_period;
  assign tick_inc = tick_r + 16'd1;
  assign bit_inc  = bit_r + 4'd1;

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    cmd_nxt   = cmd_r;
    value_nxt = value_r;
    enter     = 1'b0;
    done      = 1'b0;
    err       = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (start_req) begin
          cmd_nxt   = command;
          bit_nxt   = 4'd0;
          shift_nxt = 16'd0;
          phase_nxt = PH_S1;
          enter     = 1'b1;
        end
      end
      PH_WAIT_REL: begin
        if (data_line) begin
          phase_nxt = PH_WAIT_LOW;
          enter     = 1'b1;
        end
      end
      PH_WAIT_LOW: begin
        if (!data_line) begin
          phase_nxt = PH_RD_SETUP;
          enter     = 1'b1;
        end
      end
      default: begin
        tick_nxt = tick_inc;
        if (tick_inc >= hp) begin
          enter = 1'b1;
          case (phase_r)
            PH_S1:         phase_nxt = PH_S2;
            PH_S2:         phase_nxt = PH_S3;
            PH_S3:         phase_nxt = PH_S4;
            PH_S4:         phase_nxt = PH_S5;
            PH_S5:         phase_nxt = PH_S6;
            PH_S6:         phase_nxt = PH_CMD_SETUP;
            PH_CMD_SETUP:  phase_nxt = PH_CMD_HIGH;
            PH_CMD_HIGH: begin
              cmd_nxt   = {cmd_r[6:0], 1'b0};
              bit_nxt   = bit_inc;
              phase_nxt = (bit_inc >= CMD_BITS) ? PH_ACK_SETUP : PH_CMD_SETUP;
            end
            PH_ACK_SETUP: begin
              bit_nxt   = 4'd0;
              phase_nxt = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
              if (data_line) begin
                done      = 1'b1;
                err       = 1'b1;
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_WAIT_REL;
              end
            end
            PH_RD_SETUP:   phase_nxt = PH_RD_HIGH;
            PH_RD_HIGH: begin
              shift_nxt = {shift_r[14:0], data_line};
              bit_nxt   = bit_inc;
              phase_nxt = (bit_inc[2:0] == 3'd0) ? PH_RACK_SETUP : PH_RD_SETUP;
            end
            PH_RACK_SETUP: phase_nxt = PH_RACK_HIGH;
            PH_RACK_HIGH:  phase_nxt = PH_RACK_TAIL;
            PH_RACK_TAIL: begin
              if (bit_r == 4'd0) begin
                value_nxt = shift_r;
                done      = 1'b1;
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_RD_SETUP;
              end
            end
            default:       phase_nxt = PH_IDLE;
          endcase
        end
      end
    endcase
    if (enter) begin
      tick_nxt = 16'd0;
    end
  end

  always_comb begin
    clk_nxt = clk_r;
    drv_nxt = drv_r;
    if (enter) begin
      case (phase_nxt)
        PH_S1:         begin clk_nxt = 1'b1; drv_nxt = 1'b0; end
        PH_S2:         begin clk_nxt = 1'b1; drv_nxt = 1'b1; end
        PH_S3:         begin clk_nxt = 1'b0; drv_nxt = 1'b1; end
        PH_S4:         begin clk_nxt = 1'b1; drv_nxt = 1'b1; end
        PH_S5:         begin clk_nxt = 1'b1; drv_nxt = 1'b0; end
        PH_CMD_SETUP:  begin clk_nxt = 1'b0; drv_nxt = ~cmd_nxt[7]; end
        PH_RACK_SETUP: begin clk_nxt = 1'b0; drv_nxt = (bit_nxt == CMD_BITS); end
        PH_CMD_HIGH, PH_ACK_HIGH, PH_RD_HIGH, PH_RACK_HIGH: begin
          clk_nxt = 1'b1;
        end
        default:       begin clk_nxt = 1'b0; drv_nxt = 1'b0; end
      endcase
    end
    result.clock_out     = clk_nxt;
    result.data_pull_low = drv_nxt;
    result.busy_res      = (phase_nxt != PH_IDLE);
    result.done_res      = done;
    result.no_ack        = err;
    result.measurement   = value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= 16'd0;
      bit_r   <= 4'd0;
      shift_r <= 16'd0;
      cmd_r   <= 8'd0;
      value_r <= 16'd0;
      clk_r   <= 1'b0;
      drv_r   <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      cmd_r   <= cmd_nxt;
      value_r <= value_nxt;
      clk_r   <= clk_nxt;
      drv_r   <= drv_nxt;
    end
  end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the two-wire sensor bus measurement master core.
`timescale 1ns / 100ps

module tb;
  import sht_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_ADDR_W-1:0] HALF_ADDR = CFG_ADDR_W'(4 * CFG_IDX_HALF);

  typedef struct packed {
    logic        start;
    logic [7:0]  cmd;
    logic        dl;
    logic        chk;
    sht_result_t res;
  } tick_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  sht_in_if  in_ch ();
  sht_out_if out_ch ();

  sht_two_wire_measure_master_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // Sequencer state mirrored by the tick predictor.
  phase_t      seq_phase = PH_IDLE;
  logic [15:0] seq_ticks = '0;
  logic [3:0]  seq_bits = '0;
  logic [15:0] seq_shift = '0;
  logic [7:0]  seq_cmd = '0;
  logic [15:0] seq_value = '0;
  logic        seq_clk = 1'b0;
  logic        seq_pull = 1'b0;
  logic [15:0] cur_half = HALF_PERIOD_RESET;

  sht_result_t expected_ticks [$];
  int fail_count = 0;
  int beats_sent = 0;
  int done_seen = 0;
  int nack_seen = 0;
  int settings_used = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_trigger = 1'b0;
  logic run_nack = 1'b0;

  // One measurement with a half period of one tick, ended by a missing acknowledge.
  tick_row_t dir_tab [26] = '{
    '{1'b0, 8'hFF, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000}},
    '{1'b1, 8'h00, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000}},
    '{1'b1, 8'hFF, 1'b1, 1'b0, '0},
    '{1'b0, 8'hFF, 1'b0, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b1, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b1, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b1, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b1, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b1, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b1, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b1, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b1, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b1, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b1, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b0, 1'b0, '0},
    '{1'b0, 8'h00, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 16'h0000}}
  };

  function automatic void enter_phase(input phase_t p);
    seq_phase = p;
    seq_ticks = '0;
    case (p)
      PH_S1: begin
        seq_clk = 1'b1;
        seq_pull = 1'b0;
      end
      PH_S2, PH_S4: begin
        seq_clk = 1'b1;
        seq_pull = 1'b1;
      end
      PH_S3: begin
        seq_clk = 1'b0;
        seq_pull = 1'b1;
      end
      PH_S5: begin
        seq_clk = 1'b1;
        seq_pull = 1'b0;
      end
      PH_CMD_SETUP: begin
        seq_clk = 1'b0;
        seq_pull = ~seq_cmd[7];
      end
      PH_CMD_HIGH, PH_ACK_HIGH, PH_RD_HIGH, PH_RACK_HIGH: seq_clk = 1'b1;
      PH_RACK_SETUP: begin
        seq_clk = 1'b0;
        seq_pull = (seq_bits == CMD_BITS);
      end
      PH_S6, PH_ACK_SETUP, PH_WAIT_REL, PH_WAIT_LOW, PH_RD_SETUP, PH_RACK_TAIL: begin
        seq_clk = 1'b0;
        seq_pull = 1'b0;
      end
      default: begin
        seq_phase = PH_IDLE;
        seq_clk = 1'b0;
        seq_pull = 1'b0;
      end
    endcase
  endfunction

  function automatic sht_result_t advance_sequencer(input logic start, input logic [7:0] cmd,
                                                    input logic dl);
    sht_result_t r;
    logic [15:0] hp;
    logic done;
    logic err;
    hp = (cur_half == 16'd0) ? 16'd1 : cur_half;
    done = 1'b0;
    err = 1'b0;
    case (seq_phase)
      PH_IDLE: begin
        if (start) begin
          seq_cmd = cmd;
          seq_bits = '0;
          seq_shift = '0;
          enter_phase(PH_S1);
        end
      end
      PH_WAIT_REL: if (dl) enter_phase(PH_WAIT_LOW);
      PH_WAIT_LOW: if (!dl) enter_phase(PH_RD_SETUP);
      default: begin
        seq_ticks = seq_ticks + 16'd1;
        if (seq_ticks >= hp) begin
          case (seq_phase)
            PH_S1, PH_S2, PH_S3, PH_S4, PH_S5: enter_phase(phase_t'(seq_phase + 5'd1));
            PH_S6: enter_phase(PH_CMD_SETUP);
            PH_CMD_SETUP: enter_phase(PH_CMD_HIGH);
            PH_CMD_HIGH: begin
              seq_cmd = {seq_cmd[6:0], 1'b0};
              seq_bits = seq_bits + 4'd1;
              enter_phase(seq_bits >= CMD_BITS ? PH_ACK_SETUP : PH_CMD_SETUP);
            end
            PH_ACK_SETUP: begin
              seq_bits = '0;
              enter_phase(PH_ACK_HIGH);
            end
            PH_ACK_HIGH: begin
              if (dl) begin
                done = 1'b1;
                err = 1'b1;
                enter_phase(PH_IDLE);
              end else begin
                enter_phase(PH_WAIT_REL);
              end
            end
            PH_RD_SETUP: enter_phase(PH_RD_HIGH);
            PH_RD_HIGH: begin
              seq_shift = {seq_shift[14:0], dl};
              seq_bits = seq_bits + 4'd1;
              enter_phase(seq_bits[2:0] == 3'd0 ? PH_RACK_SETUP : PH_RD_SETUP);
            end
            PH_RACK_SETUP: enter_phase(PH_RACK_HIGH);
            PH_RACK_HIGH: enter_phase(PH_RACK_TAIL);
            PH_RACK_TAIL: begin
              if (seq_bits == 4'd0) begin
                seq_value = seq_shift;
                done = 1'b1;
                enter_phase(PH_IDLE);
              end else begin
                enter_phase(PH_RD_SETUP);
              end
            end
            default: enter_phase(PH_IDLE);
          endcase
        end
      end
    endcase
    r.clock_out = seq_clk;
    r.data_pull_low = seq_pull;
    r.busy_res = (seq_phase != PH_IDLE);
    r.done_res = done;
    r.no_ack = err;
    r.measurement = seq_value;
    return r;
  endfunction

  // Sensor side: acknowledges, releases and pulls data low as a real slave would, with noise.
  function automatic logic slave_data_level();
    if ($urandom_range(99) < 5) return 1'($urandom);
    case (seq_phase)
      PH_ACK_HIGH: return run_nack;
      PH_WAIT_REL: return ($urandom_range(3) == 0);
      PH_WAIT_LOW: return ($urandom_range(3) != 0);
      default: return 1'($urandom);
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Leaves valid high on return; the caller offers again or lowers it in the same step.
  task automatic offer_tick(input logic start, input logic [7:0] cmd, input logic dl,
                            input logic typed, input sht_result_t typed_res);
    sht_result_t res;
    if ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.start_req <= start;
    in_ch.command <= cmd;
    in_ch.data_line <= dl;
    do @(posedge clk); while (!in_ch.ready);
    res = advance_sequencer(start, cmd, dl);
    expected_ticks.push_back(typed ? typed_res : res);
    beats_sent++;
  endtask

  task automatic cfg_write(input logic [15:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= HALF_ADDR;
    cfg_pwdata <= {16'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cur_half = value;
    settings_used++;
  endtask

  task automatic cfg_read_check(input logic [15:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= HALF_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    check_field("half_period_ticks", value, cfg_prdata[15:0]);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] hp, input int gap, input int stall,
                           input int count, input bit hold);
    logic start_bit;
    while (seq_phase != PH_IDLE) offer_tick(1'b0, 8'($urandom), slave_data_level(), 1'b0, '0);
    in_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write(hp);
    cfg_read_check(hp);
    gap_pct = gap;
    stall_pct = stall;
    hold_trigger = hold;
    for (int i = 0; i < count; i++) begin
      if (seq_phase == PH_IDLE) begin
        start_bit = ($urandom_range(99) < 30);
        if (start_bit) run_nack = ($urandom_range(99) < 15);
      end else begin
        start_bit = 1'($urandom);
      end
      offer_tick(start_bit, 8'($urandom), slave_data_level(), 1'b0, '0);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.start_req <= 1'b0;
    in_ch.command <= '0;
    in_ch.data_line <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    cfg_read_check(HALF_PERIOD_RESET);
    cfg_write(16'd0);
    cfg_read_check(16'd0);
    foreach (dir_tab[i])
      offer_tick(dir_tab[i].start, dir_tab[i].cmd, dir_tab[i].dl, dir_tab[i].chk, dir_tab[i].res);
    run_phase(16'd1, 0, 0, 150, 1'b0);
    run_phase(16'd2, 50, 0, 150, 1'b0);
    run_phase(16'd0, 0, 50, 150, 1'b1);
    run_phase(16'd3, 23, 23, 150, 1'b0);
    run_phase(16'hFFFF, 0, 0, 20, 1'b0);
    in_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Checked %0d tick beats over %0d half-period settings, with idle, stall and hold-off.",
             beats_sent, settings_used);
    $display("%0d measurements ended, %0d of them on a missing acknowledge.",
             done_seen, nack_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_trigger) begin
        hold_trigger = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    sht_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_ticks.size() == 0) begin
        $error("result beat arrived with no tick pending");
        fail_count++;
      end else begin
        want = expected_ticks.pop_front();
        check_field("clock_out", 16'(want.clock_out), 16'(out_ch.clock_out));
        check_field("data_pull_low", 16'(want.data_pull_low), 16'(out_ch.data_pull_low));
        check_field("busy_res", 16'(want.busy_res), 16'(out_ch.busy_res));
        check_field("done_res", 16'(want.done_res), 16'(out_ch.done_res));
        check_field("no_ack", 16'(want.no_ack), 16'(out_ch.no_ack));
        check_field("measurement", want.measurement, out_ch.measurement);
        if (want.done_res) begin
          done_seen++;
          if (want.no_ack) nack_seen++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> sim.f
rtl/sht_pkg.sv
rtl/sht_if.sv
rtl/sht_cfg.sv
rtl/sht_seq.sv
rtl/sht_two_wire_measure_master_core.sv
tb/tb.sv
